// ===== hw/rtl/dctc_pkg.sv =====
// dctc_pkg: shared types and constants of the dram command timing checker
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package dctc_pkg;

   // bank store depth and field widths
   localparam int BANK_COUNT = 16;
   localparam int BANK_W    = 4;
   localparam int TIME_W    = 64;
   localparam int GAP_W     = 10;   // holds the sum of three 8-bit gaps
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 64;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_TIMINGS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_TIMINGS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST_CYCLES   = 2'd2;

   typedef enum logic {
      OP_CHECK = 1'b0,
      OP_ISSUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      CMD_ACTIVATE  = 2'd0,
      CMD_PRECHARGE = 2'd1,
      CMD_READ      = 2'd2,
      CMD_WRITE     = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      op_type              opcode;
      cmd_kind_type        command_kind;
      logic [BANK_W-1:0]   bank_index;
      logic [TIME_W-1:0]   now_time;
   } req_payload_type;

   typedef struct packed {
      logic timing_ok;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== hw/rtl/dctc_req_if.sv =====
// dctc_req_if: command channel carrying valid, ready and the command payload
// depends on dctc_pkg
`default_nettype none

interface dctc_req_if;
   logic                     valid;
   logic                     ready;
   dctc_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dctc_rsp_if.sv =====
// dctc_rsp_if: result channel carrying valid, ready and the timing verdict
// depends on dctc_pkg
`default_nettype none

interface dctc_rsp_if;
   logic                     valid;
   logic                     ready;
   dctc_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dram_command_timing_checker.sv =====
// dram_command_timing_checker: top level, bank timing state and checks
// depends on dctc_pkg, dctc_req_if and dctc_rsp_if
`default_nettype none

// Each command transfer yields one timing_ok result: the command sits in an input register,
// where the bank's stored times are read, three gap compares are made and the state is
// updated as the verdict moves into the result register. A new command is taken every cycle
// unless the result stalls, since the bank state's read-modify-write closes as the command
// moves on and the next command sees the recorded times. A stalled result holds the result
// register; the input register keeps taking a command while the one in it can move on.
// Stored times start as never after reset through valid bits, so no clearing pass is needed.
module dram_command_timing_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   dctc_req_if.sink                               req_chan,
   dctc_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [dctc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dctc_pkg::CSR_DAT_W-1:0]    csr_data
);

   localparam int NB = dctc_pkg::BANK_COUNT;
   localparam int TW = dctc_pkg::TIME_W;
   localparam int GW = dctc_pkg::GAP_W;

   // configuration registers
   logic [63:0] row_timings_ff;
   logic [31:0] column_timings_ff;
   logic [7:0]  burst_cycles_ff;

   // input and result registers
   logic                      s1_valid_ff, s1_valid_in;
   dctc_pkg::req_payload_type s1_item_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_ok_ff;

   // timing state
   logic [TW-1:0] any_act_ff, any_rd_ff, any_wr_ff;
   logic          any_act_vld_ff, any_rd_vld_ff, any_wr_vld_ff;
   logic [TW-1:0] bank_act_ff [NB];
   logic [TW-1:0] bank_pre_ff [NB];
   logic [TW-1:0] bank_rd_ff  [NB];
   logic [TW-1:0] bank_wr_ff  [NB];
   logic [NB-1:0] bank_act_vld_ff, bank_pre_vld_ff, bank_rd_vld_ff, bank_wr_vld_ff;
   logic [NB-1:0] bank_flag_ff;

   logic advance;
   logic req_xfer;
   logic bank_ok;
   logic record;
   logic ok;

   logic [dctc_pkg::BANK_W-1:0] bank;
   dctc_pkg::cmd_kind_type      kind;
   logic [TW-1:0]               now;

   logic [TW-1:0] any_act_rd, any_rd_rd, any_wr_rd;
   logic [TW-1:0] b_act_rd, b_pre_rd, b_rd_rd, b_wr_rd;
   logic          b_flag_rd;

   logic [GW-1:0] g_rrd, g_rc, g_rp, g_rtp, g_ras, g_wr, g_wl, g_wtr;
   logic [GW-1:0] g_ccd, g_rcd_rd, g_rcd_wr, g_rtw, g_burst;
   logic [TW-1:0] past_a, past_b, past_c;
   logic [GW-1:0] gap_a, gap_b, gap_c;
   logic          bypass_c;

   // true when past is never, or now lies at least gap after past
   function automatic logic gap_met(input logic [TW-1:0] now_t, input logic [TW-1:0] past_t,
                                    input logic [GW-1:0] gap_t);
      logic [TW-1:0] diff;
      diff = now_t - past_t;
      return (past_t == '0) || ((now_t >= past_t) && (diff >= {{(TW-GW){1'b0}}, gap_t}));
   endfunction

   // handshake control
   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   assign bank = s1_item_ff.bank_index;
   assign kind = s1_item_ff.command_kind;
   assign now  = s1_item_ff.now_time;
   assign bank_ok = ({{(32-dctc_pkg::BANK_W){1'b0}}, bank} < 32'(NB));
   assign record  = advance && bank_ok && (s1_item_ff.opcode == dctc_pkg::OP_ISSUE);

   // state reads, an invalid entry reads as never
   assign any_act_rd = any_act_vld_ff ? any_act_ff : '0;
   assign any_rd_rd  = any_rd_vld_ff  ? any_rd_ff  : '0;
   assign any_wr_rd  = any_wr_vld_ff  ? any_wr_ff  : '0;
   assign b_act_rd   = bank_act_vld_ff[bank] ? bank_act_ff[bank] : '0;
   assign b_pre_rd   = bank_pre_vld_ff[bank] ? bank_pre_ff[bank] : '0;
   assign b_rd_rd    = bank_rd_vld_ff[bank]  ? bank_rd_ff[bank]  : '0;
   assign b_wr_rd    = bank_wr_vld_ff[bank]  ? bank_wr_ff[bank]  : '0;
   assign b_flag_rd  = bank_flag_ff[bank];

   // gap fields widened for the sums
   assign g_rrd    = GW'(row_timings_ff[7:0]);
   assign g_rc     = GW'(row_timings_ff[15:8]);
   assign g_rp     = GW'(row_timings_ff[23:16]);
   assign g_rtp    = GW'(row_timings_ff[31:24]);
   assign g_ras    = GW'(row_timings_ff[39:32]);
   assign g_wr     = GW'(row_timings_ff[47:40]);
   assign g_wl     = GW'(row_timings_ff[55:48]);
   assign g_wtr    = GW'(row_timings_ff[63:56]);
   assign g_ccd    = GW'(column_timings_ff[7:0]);
   assign g_rcd_rd = GW'(column_timings_ff[15:8]);
   assign g_rcd_wr = GW'(column_timings_ff[23:16]);
   assign g_rtw    = GW'(column_timings_ff[31:24]);
   assign g_burst  = GW'(burst_cycles_ff);

   // pick the three constraints of this command
   always_comb begin
      bypass_c = 1'b0;
      unique case (kind)
         dctc_pkg::CMD_ACTIVATE: begin
            past_a = any_act_rd; gap_a = g_rrd;
            past_b = b_act_rd;   gap_b = g_rc;
            past_c = b_pre_rd;   gap_c = g_rp;
         end
         dctc_pkg::CMD_PRECHARGE: begin
            past_a = any_rd_rd;  gap_a = g_rtp;
            past_b = b_wr_rd;    gap_b = g_wr + g_wl + g_burst;
            past_c = b_act_rd;   gap_c = g_ras + g_rp;
         end
         dctc_pkg::CMD_READ: begin
            past_a = any_rd_rd;  gap_a = g_ccd;
            past_b = b_wr_rd;    gap_b = g_wtr + g_wl + g_burst;
            past_c = b_act_rd;   gap_c = g_rcd_rd;
            bypass_c = b_flag_rd;
         end
         dctc_pkg::CMD_WRITE: begin
            past_a = any_wr_rd;  gap_a = g_ccd;
            past_b = b_rd_rd;    gap_b = g_rtw;
            past_c = b_act_rd;   gap_c = g_rcd_wr;
            bypass_c = b_flag_rd;
         end
         default: begin
            past_a = '0; gap_a = '0;
            past_b = '0; gap_b = '0;
            past_c = '0; gap_c = '0;
         end
      endcase
   end

   assign ok = bank_ok && gap_met(now, past_a, gap_a) && gap_met(now, past_b, gap_b)
               && (bypass_c || gap_met(now, past_c, gap_c));

   // next values of the control registers
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         row_timings_ff    <= '0;
         column_timings_ff <= '0;
         burst_cycles_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               dctc_pkg::CSR_ROW_TIMINGS:    row_timings_ff    <= csr_data;
               dctc_pkg::CSR_COLUMN_TIMINGS: column_timings_ff <= csr_data[31:0];
               dctc_pkg::CSR_BURST_CYCLES:   burst_cycles_ff   <= csr_data[7:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_item_ff <= req_chan.payload;
      end
      if (advance) begin
         rsp_ok_ff <= ok;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.payload.timing_ok = rsp_ok_ff;

   // valid bits and accessed flags
   always_ff @(posedge clock) begin
      if (reset) begin
         any_act_vld_ff  <= 1'b0;
         any_rd_vld_ff   <= 1'b0;
         any_wr_vld_ff   <= 1'b0;
         bank_act_vld_ff <= '0;
         bank_pre_vld_ff <= '0;
         bank_rd_vld_ff  <= '0;
         bank_wr_vld_ff  <= '0;
         bank_flag_ff    <= '0;
      end else if (record) begin
         unique case (kind)
            dctc_pkg::CMD_ACTIVATE: begin
               any_act_vld_ff        <= 1'b1;
               bank_act_vld_ff[bank] <= 1'b1;
               bank_flag_ff[bank]    <= 1'b0;
            end
            dctc_pkg::CMD_PRECHARGE: begin
               bank_pre_vld_ff[bank] <= 1'b1;
            end
            dctc_pkg::CMD_READ: begin
               any_rd_vld_ff        <= 1'b1;
               bank_rd_vld_ff[bank] <= 1'b1;
               bank_flag_ff[bank]   <= 1'b1;
            end
            dctc_pkg::CMD_WRITE: begin
               any_wr_vld_ff        <= 1'b1;
               bank_wr_vld_ff[bank] <= 1'b1;
               bank_flag_ff[bank]   <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // recorded times
   always_ff @(posedge clock) begin
      if (record) begin
         unique case (kind)
            dctc_pkg::CMD_ACTIVATE: begin
               any_act_ff        <= now;
               bank_act_ff[bank] <= now;
            end
            dctc_pkg::CMD_PRECHARGE: begin
               bank_pre_ff[bank] <= now;
            end
            dctc_pkg::CMD_READ: begin
               any_rd_ff        <= now;
               bank_rd_ff[bank] <= now;
            end
            dctc_pkg::CMD_WRITE: begin
               any_wr_ff        <= now;
               bank_wr_ff[bank] <= now;
            end
            default: ;
         endcase
      end
   end

   // a command held behind a stalled result stays in the input register
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_item_ff)))
      else $error("input register lost a stalled command");

   // no new command while both registers are full and the result is stalled
   a_no_take_full: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("command taken while pipeline is full");

   // an issued activate clears the bank's accessed flag
   a_act_clears_flag: assert property (@(posedge clock) disable iff (reset)
      (record && kind == dctc_pkg::CMD_ACTIVATE) |=> !bank_flag_ff[$past(bank)])
      else $error("accessed flag not cleared by activate");

   // an issued read records its time in the any-bank read time
   a_read_time: assert property (@(posedge clock) disable iff (reset)
      (record && kind == dctc_pkg::CMD_READ) |=> (any_rd_vld_ff && any_rd_ff == $past(now)))
      else $error("read time not recorded");

   // every step out of the input register lands a result
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result register did not take the verdict");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: self-checking bench for dram_command_timing_checker, with an in-bench verdict
// predictor, a directed command script and random traffic under several timing settings
// depends on dctc_pkg, dctc_req_if, dctc_rsp_if and the dram_command_timing_checker rtl
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 100000;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_COMMANDS = 300;
   localparam int SCRIPT_LEN     = 25;
   localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

   // one scripted command; typed rows carry their verdict, the rest use the predictor
   typedef struct packed {
      dctc_pkg::op_type       opcode;
      dctc_pkg::cmd_kind_type kind;
      logic [3:0]             bank;
      logic [63:0]            at;
      logic                   typed;
      logic                   typed_ok;
   } script_cmd_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [dctc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [dctc_pkg::CSR_DAT_W-1:0] csr_data;

   dctc_req_if req_if ();
   dctc_rsp_if rsp_if ();

   dram_command_timing_checker uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // timing settings as the block should hold them
   logic [63:0] row_cfg;
   logic [31:0] col_cfg;
   logic [7:0]  burst_cfg;

   // command history as the block should hold it
   logic [63:0] last_activate_any;
   logic [63:0] last_read_any;
   logic [63:0] last_write_any;
   logic [63:0] last_activate [dctc_pkg::BANK_COUNT];
   logic [63:0] last_precharge [dctc_pkg::BANK_COUNT];
   logic [63:0] last_read [dctc_pkg::BANK_COUNT];
   logic [63:0] last_write [dctc_pkg::BANK_COUNT];
   logic        bank_touched [dctc_pkg::BANK_COUNT];

   bit   pending_verdicts [$];
   int   mismatches = 0;
   int   verdicts_met = 0;
   int   verdicts_violated = 0;
   int   commands_sent = 0;
   int   settings_used = 0;
   int   cycle_count = 0;
   bit   sender_calm = 1'b0;
   bit   sink_calm = 1'b0;
   logic [63:0] stamp = '0;

   script_cmd_type command_script [SCRIPT_LEN] = '{
      // after reset every stored time reads as never
      '{dctc_pkg::OP_CHECK, dctc_pkg::CMD_ACTIVATE, 4'd0, 64'd0, 1'b1, 1'b1},
      // an issue at time zero records zero, which still reads as never
      '{dctc_pkg::OP_ISSUE, dctc_pkg::CMD_ACTIVATE, 4'd0, 64'd0, 1'b1, 1'b1},
      '{dctc_pkg::OP_CHECK, dctc_pkg::CMD_READ, 4'd0, 64'd1, 1'b1, 1'b1},
      '{dctc_pkg::OP_ISSUE, dctc_pkg::CMD_ACTIVATE, 4'd15, 64'd100, 1'b1, 1'b1},
      '{dctc_pkg::OP_ISSUE, dctc_pkg::CMD_ACTIVATE, 4'd14, 64'd101, 1'b0, 1'b0},
      '{dctc_pkg::OP_CHECK, dctc_pkg::CMD_READ, 4'd15, 64'd103, 1'b0, 1'b0},
      '{dctc_pkg::OP_ISSUE, dctc_pkg::CMD_READ, 4'd15, 64'd104, 1'b0, 1'b0},
      '{dctc_pkg::OP_ISSUE, dctc_pkg::CMD_WRITE, 4'd15, 64'd105, 1'b0, 1'b0},
      '{dctc_pkg::OP_ISSUE, dctc_pkg::CMD_WRITE, 4'd15, 64'd110, 1'b0, 1'b0},
      '{dctc_pkg::OP_CHECK, dctc_pkg::CMD_PRECHARGE, 4'd15, 64'd111, 1'b0, 1'b0},
      '{dctc_pkg::OP_ISSUE, dctc_pkg::CMD_PRECHARGE, 4'd15, 64'd121, 1'b0, 1'b0},
      '{dctc_pkg::OP_CHECK, dctc_pkg::CMD_ACTIVATE, 4'd15, 64'd123, 1'b0, 1'b0},
      '{dctc_pkg::OP_ISSUE, dctc_pkg::CMD_ACTIVATE, 4'd15, 64'd124, 1'b0, 1'b0},
      '{dctc_pkg::OP_CHECK, dctc_pkg::CMD_WRITE, 4'd15, 64'd125, 1'b0, 1'b0},
      '{dctc_pkg::OP_ISSUE, dctc_pkg::CMD_READ, 4'd14, 64'd130, 1'b0, 1'b0},
      '{dctc_pkg::OP_ISSUE, dctc_pkg::CMD_WRITE, 4'd14, 64'd132, 1'b0, 1'b0},
      '{dctc_pkg::OP_ISSUE, dctc_pkg::CMD_PRECHARGE, 4'd14, 64'd140, 1'b0, 1'b0},
      // near the top of the time range the gap sums must not wrap
      '{dctc_pkg::OP_ISSUE, dctc_pkg::CMD_ACTIVATE, 4'd7, TIME_MAX - 64'd3, 1'b0, 1'b0},
      '{dctc_pkg::OP_CHECK, dctc_pkg::CMD_ACTIVATE, 4'd7, TIME_MAX, 1'b1, 1'b0},
      '{dctc_pkg::OP_CHECK, dctc_pkg::CMD_READ, 4'd7, TIME_MAX, 1'b1, 1'b0},
      '{dctc_pkg::OP_ISSUE, dctc_pkg::CMD_WRITE, 4'd7, TIME_MAX, 1'b0, 1'b0},
      '{dctc_pkg::OP_CHECK, dctc_pkg::CMD_PRECHARGE, 4'd7, TIME_MAX, 1'b0, 1'b0},
      // a timestamp earlier than the recorded one never passes
      '{dctc_pkg::OP_CHECK, dctc_pkg::CMD_ACTIVATE, 4'd7, 64'd5, 1'b1, 1'b0},
      '{dctc_pkg::OP_ISSUE, dctc_pkg::CMD_READ, 4'd3, 64'h5555_5555_5555_5555, 1'b0, 1'b0},
      '{dctc_pkg::OP_ISSUE, dctc_pkg::CMD_ACTIVATE, 4'd0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0}
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // a gap is met when the past time is never, or now is at least past plus gap
   function automatic bit gap_clear(input logic [63:0] now, input logic [63:0] past,
                                    input logic [63:0] gap);
      if (past == '0) return 1'b1;
      if (now < past) return 1'b0;
      return (now - past) >= gap;
   endfunction

   function automatic logic [63:0] row_gap(input int pos);
      return 64'(row_cfg[8*pos +: 8]);
   endfunction

   function automatic logic [63:0] col_gap(input int pos);
      return 64'(col_cfg[8*pos +: 8]);
   endfunction

   // verdict for one command, then the history update when it is issued
   function automatic bit timing_verdict(input dctc_pkg::req_payload_type cmd);
      logic [63:0] now;
      logic [63:0] burst;
      logic [3:0]  b;
      bit          ok;
      now   = cmd.now_time;
      b     = cmd.bank_index;
      burst = 64'(burst_cfg);
      case (cmd.command_kind)
         dctc_pkg::CMD_ACTIVATE: begin
            ok = gap_clear(now, last_activate_any, row_gap(0))
              && gap_clear(now, last_activate[b], row_gap(1))
              && gap_clear(now, last_precharge[b], row_gap(2));
         end
         dctc_pkg::CMD_PRECHARGE: begin
            ok = gap_clear(now, last_read_any, row_gap(3))
              && gap_clear(now, last_write[b], row_gap(5) + row_gap(6) + burst)
              && gap_clear(now, last_activate[b], row_gap(4) + row_gap(2));
         end
         dctc_pkg::CMD_READ: begin
            ok = gap_clear(now, last_read_any, col_gap(0))
              && (bank_touched[b] || gap_clear(now, last_activate[b], col_gap(1)))
              && gap_clear(now, last_write[b], row_gap(7) + row_gap(6) + burst);
         end
         default: begin
            ok = gap_clear(now, last_write_any, col_gap(0))
              && gap_clear(now, last_read[b], col_gap(3))
              && (bank_touched[b] || gap_clear(now, last_activate[b], col_gap(2)));
         end
      endcase
      if (cmd.opcode == dctc_pkg::OP_ISSUE) begin
         case (cmd.command_kind)
            dctc_pkg::CMD_ACTIVATE: begin
               last_activate_any = now;
               last_activate[b]  = now;
               bank_touched[b]   = 1'b0;
            end
            dctc_pkg::CMD_PRECHARGE: begin
               last_precharge[b] = now;
            end
            dctc_pkg::CMD_READ: begin
               last_read_any   = now;
               last_read[b]    = now;
               bank_touched[b] = 1'b1;
            end
            default: begin
               last_write_any  = now;
               last_write[b]   = now;
               bank_touched[b] = 1'b1;
            end
         endcase
      end
      return ok;
   endfunction

   // random command: mostly small time steps on a few banks, now and then a jump
   function automatic dctc_pkg::req_payload_type roll_command();
      dctc_pkg::req_payload_type cmd;
      int                        pick;
      pick = $urandom_range(0, 99);
      if (pick < 2) stamp = {$urandom, $urandom};
      else if (pick < 3) stamp = TIME_MAX - 64'($urandom_range(0, 600));
      else if (pick < 4) stamp = '0;
      else if (pick < 50) stamp = stamp + 64'($urandom_range(0, 8));
      else if (pick < 80) stamp = stamp + 64'($urandom_range(0, 64));
      else stamp = stamp + 64'($urandom_range(0, 800));
      cmd.opcode = ($urandom_range(0, 99) < 80) ? dctc_pkg::OP_ISSUE : dctc_pkg::OP_CHECK;
      pick = $urandom_range(0, 99);
      if (pick < 25) cmd.command_kind = dctc_pkg::CMD_ACTIVATE;
      else if (pick < 45) cmd.command_kind = dctc_pkg::CMD_PRECHARGE;
      else if (pick < 75) cmd.command_kind = dctc_pkg::CMD_READ;
      else cmd.command_kind = dctc_pkg::CMD_WRITE;
      if ($urandom_range(0, 1) == 1) cmd.bank_index = 4'($urandom_range(0, 3));
      else cmd.bank_index = 4'($urandom_range(0, 15));
      cmd.now_time = stamp;
      return cmd;
   endfunction

   // register writes, back to back, while the block is idle
   task automatic program_timings(input logic [63:0] row, input logic [31:0] col,
                                  input logic [7:0] burst);
      csr_we    <= 1'b1;
      csr_index <= dctc_pkg::CSR_ROW_TIMINGS;
      csr_data  <= row;
      @(posedge clock);
      csr_index <= dctc_pkg::CSR_COLUMN_TIMINGS;
      csr_data  <= {32'($urandom), col};
      @(posedge clock);
      csr_index <= dctc_pkg::CSR_BURST_CYCLES;
      csr_data  <= {56'h0, burst};
      @(posedge clock);
      csr_we    <= 1'b0;
      row_cfg   = row;
      col_cfg   = col;
      burst_cfg = burst;
      settings_used++;
   endtask

   // one command transfer, with random idle cycles ahead of it
   task automatic push_command(input dctc_pkg::req_payload_type cmd, input bit typed,
                               input bit typed_ok);
      bit verdict;
      while (!sender_calm && $urandom_range(0, 99) < 9) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= cmd;
      do @(posedge clock); while (!req_if.ready);
      verdict = timing_verdict(cmd);
      pending_verdicts.push_back(typed ? typed_ok : verdict);
      commands_sent++;
   endtask

   // stop sending and let every outstanding verdict come back
   task automatic drain_verdicts();
      req_if.valid <= 1'b0;
      while (pending_verdicts.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // result side backpressure
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= sink_calm || ($urandom_range(0, 99) >= 9);
      end
   end

   // compare each verdict transfer with the oldest prediction
   always @(posedge clock) begin : verdict_monitor
      bit want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: timing_ok %0b arrived with no command outstanding",
                     $realtime, rsp_if.payload.timing_ok);
            mismatches++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_if.payload.timing_ok !== want) begin
               $display("%0t: timing_ok expected %0b actual %0b",
                        $realtime, want, rsp_if.payload.timing_ok);
               mismatches++;
            end
            if (want) verdicts_met++;
            else verdicts_violated++;
         end
      end
   end

   // watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d verdicts outstanding",
               cycle_count, pending_verdicts.size());
      $display("== FAIL ==");
      $finish;
   end

   // main sequence
   initial begin
      logic [63:0] row;
      logic [31:0] col;
      logic [7:0]  burst;
      dctc_pkg::req_payload_type cmd;

      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      csr_we         <= 1'b0;
      csr_index      <= dctc_pkg::CSR_ROW_TIMINGS;
      csr_data       <= '0;
      row_cfg           = '0;
      col_cfg           = '0;
      burst_cfg         = '0;
      last_activate_any = '0;
      last_read_any     = '0;
      last_write_any    = '0;
      for (int i = 0; i < dctc_pkg::BANK_COUNT; i++) begin
         last_activate[i]  = '0;
         last_precharge[i] = '0;
         last_read[i]      = '0;
         last_write[i]     = '0;
         bank_touched[i]   = 1'b0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed script under moderate gaps
      program_timings(64'h0302_0506_0403_0A02, 32'h0305_0402, 8'd4);
      foreach (command_script[i]) begin
         cmd.opcode       = command_script[i].opcode;
         cmd.command_kind = command_script[i].kind;
         cmd.bank_index   = command_script[i].bank;
         cmd.now_time     = command_script[i].at;
         push_command(cmd, command_script[i].typed, command_script[i].typed_ok);
      end
      drain_verdicts();

      // random traffic: no gaps, widest gaps, small random gaps, fully random gaps
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               row = '0;
               col = '0;
               burst = '0;
            end
            1: begin
               row = '1;
               col = '1;
               burst = '1;
            end
            RANDOM_PHASES - 1: begin
               row = {$urandom, $urandom};
               col = $urandom;
               burst = 8'($urandom_range(0, 255));
            end
            default: begin
               for (int i = 0; i < 8; i++) row[8*i +: 8] = 8'($urandom_range(0, 31));
               for (int i = 0; i < 4; i++) col[8*i +: 8] = 8'($urandom_range(0, 31));
               burst = 8'($urandom_range(0, 15));
            end
         endcase
         program_timings(row, col, burst);
         sender_calm = (phase == 3);
         sink_calm   = (phase == 3) || (phase == 4);
         repeat (PHASE_COMMANDS) push_command(roll_command(), 1'b0, 1'b0);
         drain_verdicts();
      end

      $display("%0d commands under %0d timing settings: %0d met timing, %0d violated",
               commands_sent, settings_used, verdicts_met, verdicts_violated);
      $display("%0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
